// ===== rtl/refcounted_poll_scheduler_backoff_macros.svh =====
// Assertion macros shared by the poll scheduler modules.
// Depends on nothing; included by the modules that check their own logic.
`ifndef REFCOUNTED_POLL_SCHEDULER_BACKOFF_MACROS_SVH
`define REFCOUNTED_POLL_SCHEDULER_BACKOFF_MACROS_SVH

// Condition implies consequence in the same cycle.
`define RPSB_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Condition implies consequence in the next cycle.
`define RPSB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/rpsb_pkg.sv =====
// Shared types and constants of the poll scheduler.
// Depends on nothing; used by every module of the block.
package rpsb_pkg;

    localparam int DefTableDepth  = 16;
    localparam logic [15:0] RstMinPeriod  = 16'd10;
    localparam logic [15:0] RstMaxBackoff = 16'd2000;
    localparam int MaxOut   = 16;
    localparam int KeyW     = 40;
    localparam int CountW   = 5;
    localparam int QDepth   = 2;

    // Configuration register indexes.
    localparam logic [0:0] CfgMinPeriod  = 1'b0;
    localparam logic [0:0] CfgMaxBackoff = 1'b1;

    typedef enum logic [1:0] {
        REQ_ACQUIRE = 2'd0,
        REQ_RELEASE = 2'd1,
        REQ_TICK    = 2'd2,
        REQ_RESULT  = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_NOT_FOUND = 2'd1,
        STAT_FULL      = 2'd2
    } t_status;

    typedef enum logic {
        KIND_STATUS = 1'b0,
        KIND_POLL   = 1'b1
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EXEC,
        ST_EMIT,
        ST_TICK,
        ST_FLUSH
    } t_state;

    typedef struct packed {
        t_req             req;
        logic [KeyW-1:0]  key;
        logic [15:0]      period;
        logic             ok;
    } t_item;

    // Head of the queue between front and back.
    typedef struct packed {
        logic  valid;
        t_item item;
    } t_head;

    typedef struct packed {
        t_kind             kind;
        t_status           status;
        logic [KeyW-1:0]   key;
        logic [CountW-1:0] tracked;
        logic              last;
    } t_result;

endpackage

// ===== rtl/rpsb_front.sv =====
// Front end: accepts words, builds the key, clamps the period and queues items.
// Depends on rpsb_pkg and the assertion macro header.
`include "refcounted_poll_scheduler_backoff_macros.svh"

module rpsb_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [1:0]          i_req_type,
    input  logic [15:0]         i_device_position,
    input  logic [15:0]         i_object_index,
    input  logic [7:0]          i_object_subindex,
    input  logic [15:0]         i_period_ms,
    input  logic                i_poll_ok,
    input  logic [15:0]         i_min_period,
    input  logic                i_pop,
    output rpsb_pkg::t_head     o_head
);

    rpsb_pkg::t_item r_q [rpsb_pkg::QDepth];
    logic            r_wptr, r_rptr;
    logic [1:0]      r_count;
    logic [1:0]      n_count;
    logic            w_push, w_pop;
    rpsb_pkg::t_item w_item;

    assign o_ready = (r_count != 2'(rpsb_pkg::QDepth));
    assign w_push  = i_valid && o_ready;
    assign w_pop   = i_pop && (r_count != 2'd0);

    always_comb begin
        w_item.req    = rpsb_pkg::t_req'(i_req_type);
        w_item.key    = {i_device_position, i_object_index, i_object_subindex};
        w_item.period = (i_period_ms < i_min_period) ? i_min_period : i_period_ms;
        w_item.ok     = i_poll_ok;
    end

    always_comb begin
        n_count = r_count + 2'(w_push) - 2'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
            if (w_push) begin
                r_wptr <= ~r_wptr;
            end
            if (w_pop) begin
                r_rptr <= ~r_rptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wptr] <= w_item;
        end
    end

    assign o_head.valid = (r_count != 2'd0);
    assign o_head.item  = r_q[r_rptr];

    `RPSB_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= 2'(rpsb_pkg::QDepth), "queue overfilled")
    `RPSB_ASSERT_NEXT(a_push_only, i_clk, i_rst_n, w_push && !w_pop, r_count == $past(r_count) + 2'd1, "push lost")
    `RPSB_ASSERT_NOW(a_pop_nonempty, i_clk, i_rst_n, i_pop, r_count != 2'd0, "pop from empty queue")

endmodule

// ===== rtl/rpsb_back.sv =====
// Back end: the object table, its sequencer and the output register.
// Depends on rpsb_pkg and the assertion macro header.
`include "refcounted_poll_scheduler_backoff_macros.svh"

module rpsb_back #(
    parameter int TABLE_DEPTH = rpsb_pkg::DefTableDepth
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rpsb_pkg::t_head     i_head,
    output logic                o_pop,
    input  logic [15:0]         i_max_backoff,
    output logic                o_valid,
    input  logic                i_ready,
    output rpsb_pkg::t_result   o_result
);

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int TW = $clog2(TABLE_DEPTH + 1);
    localparam logic [IW-1:0] LastIdx = IW'(TABLE_DEPTH - 1);

    logic                      r_valid   [TABLE_DEPTH];
    logic                      r_pending [TABLE_DEPTH];
    logic [rpsb_pkg::KeyW-1:0] r_key     [TABLE_DEPTH];
    logic [7:0]                r_ref     [TABLE_DEPTH];
    logic [15:0]               r_per     [TABLE_DEPTH];
    logic [15:0]               r_boff    [TABLE_DEPTH];
    logic [15:0]               r_cd      [TABLE_DEPTH];

    rpsb_pkg::t_state  r_state, n_state;
    rpsb_pkg::t_item   r_item;
    logic [IW-1:0]     r_idx, r_slot, r_free;
    logic              r_found, r_free_v;
    logic [TW-1:0]     r_total;
    rpsb_pkg::t_status r_status;
    logic [rpsb_pkg::CountW-1:0] r_n;
    logic                        r_held_v;
    logic [rpsb_pkg::KeyW-1:0]   r_held;
    logic              r_out_valid;
    rpsb_pkg::t_result r_out;

    logic        w_out_free, w_last_idx;
    logic        w_act, w_due, w_stall;
    logic [15:0] w_cd_n;
    logic [16:0] w_dbl;
    logic [16:0] w_next;
    logic [7:0]  w_ref_dec;
    logic        w_tick_adv;
    logic        w_out_load;

    assign w_out_free = !r_out_valid || i_ready;
    assign w_last_idx = (r_idx == LastIdx);

    // Tick evaluation of the entry under the scan index.
    assign w_act   = r_valid[r_idx] && !r_pending[r_idx]
                     && (r_n < rpsb_pkg::CountW'(rpsb_pkg::MaxOut));
    assign w_cd_n  = (r_cd[r_idx] != 16'd0) ? (r_cd[r_idx] - 16'd1) : r_cd[r_idx];
    assign w_due   = w_act && (w_cd_n == 16'd0);
    assign w_stall = w_due && r_held_v && !w_out_free;
    assign w_tick_adv = (r_state == rpsb_pkg::ST_TICK) && !w_stall;

    // A new word enters the output register in these cases.
    assign w_out_load = ((r_state == rpsb_pkg::ST_EMIT) && w_out_free)
                        || (w_tick_adv && w_due && r_held_v)
                        || ((r_state == rpsb_pkg::ST_FLUSH) && r_held_v && w_out_free);

    // Retry backoff: period first, then doubling, capped.
    assign w_dbl  = (r_boff[r_slot] == 16'd0) ? {1'b0, r_per[r_slot]}
                                              : {r_boff[r_slot], 1'b0};
    assign w_next = (w_dbl > {1'b0, i_max_backoff}) ? {1'b0, i_max_backoff} : w_dbl;
    assign w_ref_dec = (r_ref[r_slot] != 8'd0) ? (r_ref[r_slot] - 8'd1) : 8'd0;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            rpsb_pkg::ST_IDLE: begin
                if (i_head.valid) begin
                    n_state = (i_head.item.req == rpsb_pkg::REQ_TICK) ?
                              rpsb_pkg::ST_TICK : rpsb_pkg::ST_SCAN;
                end
            end
            rpsb_pkg::ST_SCAN: begin
                if (w_last_idx) begin
                    n_state = rpsb_pkg::ST_EXEC;
                end
            end
            rpsb_pkg::ST_EXEC: n_state = rpsb_pkg::ST_EMIT;
            rpsb_pkg::ST_EMIT: begin
                if (w_out_free) begin
                    n_state = rpsb_pkg::ST_IDLE;
                end
            end
            rpsb_pkg::ST_TICK: begin
                if (w_tick_adv && w_last_idx) begin
                    n_state = rpsb_pkg::ST_FLUSH;
                end
            end
            rpsb_pkg::ST_FLUSH: begin
                if (!r_held_v || w_out_free) begin
                    n_state = rpsb_pkg::ST_IDLE;
                end
            end
            default: n_state = rpsb_pkg::ST_IDLE;
        endcase
    end

    // Outputs of the sequencer.
    always_comb begin
        o_pop = (r_state == rpsb_pkg::ST_IDLE) && i_head.valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rpsb_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Sequencer registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_found     <= 1'b0;
            r_free_v    <= 1'b0;
            r_total     <= '0;
            r_n         <= '0;
            r_held_v    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                rpsb_pkg::ST_IDLE: begin
                    r_idx    <= '0;
                    r_found  <= 1'b0;
                    r_free_v <= 1'b0;
                    r_n      <= '0;
                    r_held_v <= 1'b0;
                    if (o_pop) begin
                        r_item <= i_head.item;
                    end
                end
                rpsb_pkg::ST_SCAN: begin
                    if (r_valid[r_idx] && (r_key[r_idx] == r_item.key)) begin
                        r_found <= 1'b1;
                        r_slot  <= r_idx;
                    end
                    if (!r_valid[r_idx] && !r_free_v) begin
                        r_free_v <= 1'b1;
                        r_free   <= r_idx;
                    end
                    if (!w_last_idx) begin
                        r_idx <= r_idx + IW'(1);
                    end
                end
                rpsb_pkg::ST_EXEC: begin
                    r_status <= rpsb_pkg::STAT_OK;
                    case (r_item.req)
                        rpsb_pkg::REQ_ACQUIRE: begin
                            if (!r_found) begin
                                if (r_free_v) begin
                                    r_total <= r_total + TW'(1);
                                end else begin
                                    r_status <= rpsb_pkg::STAT_FULL;
                                end
                            end
                        end
                        rpsb_pkg::REQ_RELEASE: begin
                            if (!r_found) begin
                                r_status <= rpsb_pkg::STAT_NOT_FOUND;
                            end else if (w_ref_dec == 8'd0 && r_total != '0) begin
                                r_total <= r_total - TW'(1);
                            end
                        end
                        default: begin
                            if (!r_found) begin
                                r_status <= rpsb_pkg::STAT_NOT_FOUND;
                            end
                        end
                    endcase
                end
                rpsb_pkg::ST_EMIT: begin
                    if (w_out_free) begin
                        r_out.kind     <= rpsb_pkg::KIND_STATUS;
                        r_out.status   <= r_status;
                        r_out.key      <= r_item.key;
                        r_out.tracked  <= rpsb_pkg::CountW'(r_total);
                        r_out.last     <= 1'b1;
                    end
                end
                rpsb_pkg::ST_TICK: begin
                    if (w_tick_adv) begin
                        if (w_due) begin
                            r_held_v <= 1'b1;
                            r_held   <= r_key[r_idx];
                            r_n      <= r_n + rpsb_pkg::CountW'(1);
                            if (r_held_v) begin
                                r_out.kind    <= rpsb_pkg::KIND_POLL;
                                r_out.status  <= rpsb_pkg::STAT_OK;
                                r_out.key     <= r_held;
                                r_out.tracked <= rpsb_pkg::CountW'(r_total);
                                r_out.last    <= 1'b0;
                            end
                        end
                        if (!w_last_idx) begin
                            r_idx <= r_idx + IW'(1);
                        end
                    end
                end
                rpsb_pkg::ST_FLUSH: begin
                    if (r_held_v && w_out_free) begin
                        r_out.kind    <= rpsb_pkg::KIND_POLL;
                        r_out.status  <= rpsb_pkg::STAT_OK;
                        r_out.key     <= r_held;
                        r_out.tracked <= rpsb_pkg::CountW'(r_total);
                        r_out.last    <= 1'b1;
                    end
                end
                default: begin
                    r_idx <= '0;
                end
            endcase
        end
    end

    // Valid and pending bits, cleared by reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                r_valid[i]   <= 1'b0;
                r_pending[i] <= 1'b0;
            end
        end else if (r_state == rpsb_pkg::ST_EXEC) begin
            case (r_item.req)
                rpsb_pkg::REQ_ACQUIRE: begin
                    if (!r_found && r_free_v) begin
                        r_valid[r_free]   <= 1'b1;
                        r_pending[r_free] <= 1'b0;
                    end
                end
                rpsb_pkg::REQ_RELEASE: begin
                    if (r_found && w_ref_dec == 8'd0) begin
                        r_valid[r_slot]   <= 1'b0;
                        r_pending[r_slot] <= 1'b0;
                    end
                end
                rpsb_pkg::REQ_RESULT: begin
                    if (r_found) begin
                        r_pending[r_slot] <= 1'b0;
                    end
                end
                default: begin
                    r_pending[r_slot] <= r_pending[r_slot];
                end
            endcase
        end else if (w_tick_adv && w_due) begin
            r_pending[r_idx] <= 1'b1;
        end
    end

    // Entry payload, written at one address a cycle.
    always_ff @(posedge i_clk) begin
        if (r_state == rpsb_pkg::ST_EXEC) begin
            case (r_item.req)
                rpsb_pkg::REQ_ACQUIRE: begin
                    if (r_found) begin
                        if (r_ref[r_slot] != 8'hFF) begin
                            r_ref[r_slot] <= r_ref[r_slot] + 8'd1;
                        end
                        if (r_item.period < r_per[r_slot]) begin
                            r_per[r_slot] <= r_item.period;
                        end
                    end else if (r_free_v) begin
                        r_key[r_free]  <= r_item.key;
                        r_ref[r_free]  <= 8'd1;
                        r_per[r_free]  <= r_item.period;
                        r_boff[r_free] <= 16'd0;
                        r_cd[r_free]   <= 16'd0;
                    end
                end
                rpsb_pkg::REQ_RELEASE: begin
                    if (r_found) begin
                        r_ref[r_slot] <= w_ref_dec;
                    end
                end
                rpsb_pkg::REQ_RESULT: begin
                    if (r_found) begin
                        if (r_item.ok) begin
                            r_boff[r_slot] <= 16'd0;
                            r_cd[r_slot]   <= r_per[r_slot];
                        end else begin
                            r_boff[r_slot] <= w_next[15:0];
                            r_cd[r_slot]   <= w_next[15:0];
                        end
                    end
                end
                default: begin
                    r_cd[r_slot] <= r_cd[r_slot];
                end
            endcase
        end else if (w_tick_adv && w_act) begin
            r_cd[r_idx] <= w_cd_n;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    `RPSB_ASSERT_NOW(a_total_bound, i_clk, i_rst_n, 1'b1, r_total <= TW'(TABLE_DEPTH), "entry count above table depth")
    `RPSB_ASSERT_NEXT(a_tick_total, i_clk, i_rst_n, r_state == rpsb_pkg::ST_TICK, r_total == $past(r_total), "tick changed entry count")
    `RPSB_ASSERT_NOW(a_cap, i_clk, i_rst_n, 1'b1, r_n <= rpsb_pkg::CountW'(rpsb_pkg::MaxOut), "too many poll requests in one tick")
    `RPSB_ASSERT_NOW(a_pop_idle, i_clk, i_rst_n, o_pop, r_state == rpsb_pkg::ST_IDLE, "item taken while busy")

endmodule

// ===== rtl/refcounted_poll_scheduler_backoff.sv =====
// Top level of the poll scheduler: configuration registers, front end, back end.
// Depends on rpsb_pkg, rpsb_front and rpsb_back.
//
// Usage. Request words enter on the s_ stream: tuser carries the request type
// (acquire, release, millisecond tick, poll result) and tdata the object key,
// the requested period and the poll outcome. Result words leave on the m_
// stream: tuser marks a status answer or a poll request, tlast flags the final
// word that one request causes. Acquire, release and poll result each give one
// status answer; a tick gives one poll request per entry that falls due, in
// table order, at most 16 per tick, and nothing when no entry is due.
// Sequencing. The front end queues up to two requests. The back end sweeps the
// table one entry per cycle through a single table port, pausing a tick sweep
// while the output stalls; a keyed request passes through the scan, execute
// and emit states to a registered status word before the next one is taken.
// Reset (synchronous, active low) empties the table and the queue and loads the
// minimum period with 10 ms and the backoff ceiling with 2000 ms.
// When the receiver holds m_tready low the tick sweep pauses at the next due
// entry and the queue keeps taking words until it is full; nothing is dropped.
// The configuration port is always ready; write it only while the block is idle.

module refcounted_poll_scheduler_backoff #(
    parameter int TABLE_DEPTH = rpsb_pkg::DefTableDepth
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [15:0] device_position, [31:16] object_index, [39:32] object_subindex,
    // [55:40] period_ms, [56] poll_ok, [63:57] zero
    input  logic [63:0] s_tdata,
    // [1:0] req_type
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [1:0] status, [17:2] out_device_position, [33:18] out_object_index,
    // [41:34] out_object_subindex, [46:42] tracked_count, [47] zero
    output logic [47:0] m_tdata,
    // [0] out_kind
    output logic [0:0]  m_tuser,
    output logic        m_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [0:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    logic [15:0]       r_min_period, r_max_backoff;
    rpsb_pkg::t_head   w_head;
    logic              w_pop;
    rpsb_pkg::t_result w_res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_period  <= rpsb_pkg::RstMinPeriod;
            r_max_backoff <= rpsb_pkg::RstMaxBackoff;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                rpsb_pkg::CfgMinPeriod:  r_min_period  <= i_cfg_data;
                rpsb_pkg::CfgMaxBackoff: r_max_backoff <= i_cfg_data;
                default:                 r_min_period  <= r_min_period;
            endcase
        end
    end

    rpsb_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (s_tvalid),
        .o_ready           (s_tready),
        .i_req_type        (s_tuser),
        .i_device_position (s_tdata[15:0]),
        .i_object_index    (s_tdata[31:16]),
        .i_object_subindex (s_tdata[39:32]),
        .i_period_ms       (s_tdata[55:40]),
        .i_poll_ok         (s_tdata[56]),
        .i_min_period      (r_min_period),
        .i_pop             (w_pop),
        .o_head            (w_head)
    );

    rpsb_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (w_head),
        .o_pop         (w_pop),
        .i_max_backoff (r_max_backoff),
        .o_valid       (m_tvalid),
        .i_ready       (m_tready),
        .o_result      (w_res)
    );

    // The key is position, index, subindex from the top bit down.
    assign m_tdata = {1'b0, w_res.tracked, w_res.key[7:0], w_res.key[23:8],
                      w_res.key[39:24], w_res.status};
    assign m_tuser = w_res.kind;
    assign m_tlast = w_res.last;

endmodule
